FILE: rtl/core/cylindrical_warp_address_top_defines.svh
// ----------------------------------------------------------------------------
// Cylindrical warp address generator: assertion macros
// Shared concurrent check wrappers, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CYLINDRICAL_WARP_ADDRESS_TOP_DEFINES_SVH
`define CYLINDRICAL_WARP_ADDRESS_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CWA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cwa: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define CWA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cwa: next-cycle check failed");

`endif

FILE: rtl/core/cwa_pkg.sv
// ----------------------------------------------------------------------------
// cwa_pkg
// Types, widths and constants of the cylindrical warp address pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cwa_pkg;

	localparam int CW       = 12;  // coordinate field
	localparam int DIMW     = 13;  // image dimension register
	localparam int FDW      = 29;  // focal distance Q13.16
	localparam int IRW      = 24;  // inverse radius Q0.24
	localparam int CHW      = 17;  // cos half fov Q1.16
	localparam int CFGW     = 29;
	localparam int CFG_IDXW = 3;

	localparam int THW      = 38;        // x * inv_radius
	localparam int THETAW   = THW + 6;   // theta Q.30
	localparam int ZW       = 34;        // cordic angle
	localparam int XW       = 34;        // cordic vector
	localparam int NW       = 60;        // dividend magnitude
	localparam int QW       = 28;        // quotient bits kept
	localparam int DENW     = 31;        // divisor (positive cosine)
	localparam int RW       = NW - QW;   // partial remainder
	localparam int YPW      = CW + CHW;  // |y| * cos_half_fov
	localparam int Q30      = 30;
	localparam int BW       = 30;        // signed Q.16 bound compare
	localparam int SW       = 31;        // rounding sum
	localparam int PW       = SW - 16;   // rounded coordinate before clamp
	localparam int LANES    = 2;         // x and y dividers

	localparam logic signed [XW-1:0]     CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [THETAW-1:0] HALF_PI     = 44'sd1686629713;
	localparam logic signed [THETAW-1:0] NEG_HALF_PI = -44'sd1686629713;
	localparam logic signed [BW-1:0]     ONE_Q16     = 30'sd65536;
	localparam logic signed [SW-1:0]     HALF_Q16    = 31'sd32768;

	typedef enum logic [CFG_IDXW-1:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_FOCAL        = 3'd2,
		CFG_INV_RADIUS   = 3'd3,
		CFG_COS_HALF_FOV = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CW-1:0] out_col;
		logic [CW-1:0] out_row;
	} pix_t;

	typedef struct packed {
		logic [CW-1:0] src_col;
		logic [CW-1:0] src_row;
		logic          remapped;
	} src_t;

	// per-item sideband carried along the pipe
	typedef struct packed {
		logic [CW-1:0]          col;
		logic [CW-1:0]          row;
		logic signed [DIMW-1:0] y;
		logic                   ok;
	} side_t;

	// round(atan(2^-i) * 2^30)
	function automatic logic [ZW-1:0] atan_q30(input int idx);
		logic [ZW-1:0] a;
		case (idx)
			0:  a = 34'd843314857;
			1:  a = 34'd497837829;
			2:  a = 34'd263043837;
			3:  a = 34'd133525159;
			4:  a = 34'd67021687;
			5:  a = 34'd33543516;
			6:  a = 34'd16775851;
			7:  a = 34'd8388437;
			8:  a = 34'd4194283;
			9:  a = 34'd2097149;
			10: a = 34'd1048576;
			11: a = 34'd524288;
			12: a = 34'd262144;
			13: a = 34'd131072;
			14: a = 34'd65536;
			15: a = 34'd32768;
			16: a = 34'd16384;
			17: a = 34'd8192;
			18: a = 34'd4096;
			19: a = 34'd2048;
			20: a = 34'd1024;
			21: a = 34'd512;
			22: a = 34'd256;
			23: a = 34'd128;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cwa_cordic.sv
// ----------------------------------------------------------------------------
// cwa_cordic
// Rotation-mode CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cwa_cordic #(
	parameter int ITER = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_v,
	input  logic signed [cwa_pkg::ZW-1:0]  z_in,
	input  cwa_pkg::side_t                 side_in,
	output logic                           out_v,
	output logic signed [cwa_pkg::XW-1:0]  cos_out,
	output logic signed [cwa_pkg::XW-1:0]  sin_out,
	output cwa_pkg::side_t                 side_out
);
	import cwa_pkg::*;

	logic                 v_s    [ITER];
	logic signed [XW-1:0] cx_s   [ITER];
	logic signed [XW-1:0] cy_s   [ITER];
	logic signed [ZW-1:0] z_s    [ITER];
	side_t                side_s [ITER];

	for (genvar i = 0; i < ITER; i++) begin : g_stage
		logic signed [XW-1:0] cx_d, cy_d, dx, dy;
		logic signed [ZW-1:0] z_d, ang;
		logic                 v_d;
		side_t                side_d;

		if (i == 0) begin : g_first
			assign cx_d   = CORDIC_GAIN;
			assign cy_d   = '0;
			assign z_d    = z_in;
			assign v_d    = in_v;
			assign side_d = side_in;
		end else begin : g_next
			assign cx_d   = cx_s[i-1];
			assign cy_d   = cy_s[i-1];
			assign z_d    = z_s[i-1];
			assign v_d    = v_s[i-1];
			assign side_d = side_s[i-1];
		end

		assign dx  = cy_d >>> i;
		assign dy  = cx_d >>> i;
		assign ang = $signed(atan_q30(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_d[ZW-1]) begin
					cx_s[i] <= cx_d - dx;
					cy_s[i] <= cy_d + dy;
					z_s[i]  <= z_d - ang;
				end else begin
					cx_s[i] <= cx_d + dx;
					cy_s[i] <= cy_d - dy;
					z_s[i]  <= z_d + ang;
				end
				side_s[i] <= side_d;
			end
		end
	end

	assign out_v    = v_s[ITER-1];
	assign cos_out  = cx_s[ITER-1];
	assign sin_out  = cy_s[ITER-1];
	assign side_out = side_s[ITER-1];

endmodule

`default_nettype wire

FILE: rtl/core/cwa_div.sv
// ----------------------------------------------------------------------------
// cwa_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Quotients at or above 2^QW are flagged as overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module cwa_div (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          in_v,
	input  logic [cwa_pkg::LANES-1:0][cwa_pkg::NW-1:0]    num_in,
	input  logic [cwa_pkg::LANES-1:0]                     neg_in,
	input  logic [cwa_pkg::DENW-1:0]                      den_in,
	input  cwa_pkg::side_t                                side_in,
	output logic                                          out_v,
	output logic [cwa_pkg::LANES-1:0][cwa_pkg::QW-1:0]    quo_out,
	output logic [cwa_pkg::LANES-1:0]                     ovf_out,
	output logic [cwa_pkg::LANES-1:0]                     neg_out,
	output cwa_pkg::side_t                                side_out
);
	import cwa_pkg::*;

	logic                          v_s   [QW+1];
	logic [DENW-1:0]               den_s [QW+1];
	side_t                         side_s[QW+1];
	logic [LANES-1:0][RW-1:0]      rem_s [QW+1];
	logic [LANES-1:0][QW-1:0]      lo_s  [QW+1];
	logic [LANES-1:0][QW-1:0]      quo_s [QW+1];
	logic [LANES-1:0]              ovf_s [QW+1];
	logic [LANES-1:0]              neg_s [QW+1];

	// setup: upper dividend bits form the first remainder
	logic [LANES-1:0][RW-1:0] rem0_c;
	logic [LANES-1:0][QW-1:0] lo0_c;
	logic [LANES-1:0]         ovf0_c;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem0_c[l] = num_in[l][NW-1:QW];
			lo0_c[l]  = num_in[l][QW-1:0];
			ovf0_c[l] = rem0_c[l] >= RW'(den_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= rem0_c;
			lo_s[0]   <= lo0_c;
			quo_s[0]  <= '0;
			ovf_s[0]  <= ovf0_c;
			neg_s[0]  <= neg_in;
			den_s[0]  <= den_in;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [LANES-1:0][RW-1:0] t_c, rem_c;
		logic [LANES-1:0][QW-1:0] lo_c, quo_c;
		logic [LANES-1:0]         ge_c;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				t_c[l]   = {rem_s[k-1][l][RW-2:0], lo_s[k-1][l][QW-1]};
				ge_c[l]  = t_c[l] >= RW'(den_s[k-1]);
				rem_c[l] = ge_c[l] ? t_c[l] - RW'(den_s[k-1]) : t_c[l];
				lo_c[l]  = {lo_s[k-1][l][QW-2:0], 1'b0};
				quo_c[l] = {quo_s[k-1][l][QW-2:0], ge_c[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_c;
				lo_s[k]   <= lo_c;
				quo_s[k]  <= quo_c;
				ovf_s[k]  <= ovf_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_v    = v_s[QW];
	assign quo_out  = quo_s[QW];
	assign ovf_out  = ovf_s[QW];
	assign neg_out  = neg_s[QW];
	assign side_out = side_s[QW];

endmodule

`default_nettype wire

FILE: rtl/core/cylindrical_warp_address_top.sv
// Throughput: one item per cycle while pix_stall is low; 3 front stages, one CORDIC
// stage per iteration, a multiply stage, a 29-stage divider (a setup stage, then
// one quotient bit a stage), 2 placement stages.
// One result register plus a one-entry skid; pix_stall rises only when the skid is full.
// Reset clears all valid bits and loads the registers with 640x480 defaults.
// ----------------------------------------------------------------------------
// cylindrical_warp_address_top
// Source address generator for a cylindrical inverse warp.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cylindrical_warp_address_top_defines.svh"

module cylindrical_warp_address_top #(
	parameter int COORD_BITS      = 12,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  cwa_pkg::pix_t                     pix_data,
	output logic                              src_valid,
	input  logic                              src_stall,
	output cwa_pkg::src_t                     src_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cwa_pkg::CFG_IDXW-1:0]      cfg_index,
	input  logic [cwa_pkg::CFGW-1:0]          cfg_data
);
	import cwa_pkg::*;

	localparam logic [CW-1:0] COORD_MASK =
		(COORD_BITS >= CW) ? {CW{1'b1}} : CW'((1 << COORD_BITS) - 1);
	localparam logic [PW-1:0] CMAX = PW'(COORD_MASK);

	// configuration registers
	logic [DIMW-1:0] width_q, height_q;
	logic [FDW-1:0]  focal_q;
	logic [IRW-1:0]  inv_q;
	logic [CHW-1:0]  chf_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			focal_q  <= 29'd32296140;
			inv_q    <= 24'd28553;
			chf_q    <= 17'd54964;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[DIMW-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[DIMW-1:0];
				CFG_FOCAL:        focal_q  <= cfg_data[FDW-1:0];
				CFG_INV_RADIUS:   inv_q    <= cfg_data[IRW-1:0];
				CFG_COS_HALF_FOV: chf_q    <= cfg_data[CHW-1:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] hw, hh;
	assign hw = width_q[DIMW-1:1];
	assign hh = height_q[DIMW-1:1];

	logic en, skid_v_q;
	assign en        = !skid_v_q;
	assign pix_stall = skid_v_q;

	// ---- stage 1: center and inner range check
	logic [CW-1:0]          col_c, row_c;
	logic signed [DIMW-1:0] x_c, y_c, lox_c, hix_c, loy_c, hiy_c;
	logic                   inr_c;

	assign col_c = pix_data.out_col & COORD_MASK;
	assign row_c = pix_data.out_row & COORD_MASK;
	assign x_c   = $signed({1'b0, col_c}) - $signed({1'b0, hw});
	assign y_c   = $signed({1'b0, row_c}) - $signed({1'b0, hh});
	assign lox_c = $signed(DIMW'(1)) - $signed({1'b0, hw});
	assign hix_c = $signed({1'b0, hw}) - $signed(DIMW'(1));
	assign loy_c = $signed(DIMW'(1)) - $signed({1'b0, hh});
	assign hiy_c = $signed({1'b0, hh}) - $signed(DIMW'(1));
	assign inr_c = (x_c >= lox_c) && (x_c <= hix_c) && (y_c >= loy_c) && (y_c <= hiy_c);

	logic                   v_s1;
	logic signed [DIMW-1:0] x_s1;
	side_t                  side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_c;
			side_s1 <= '{col: col_c, row: row_c, y: y_c, ok: inr_c};
		end
	end

	// ---- stage 2: x * inv_radius
	logic signed [THW-1:0] th_c;
	assign th_c = THW'(x_s1) * THW'($signed({1'b0, inv_q}));

	logic                  v_s2;
	logic signed [THW-1:0] th_s2;
	side_t                 side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_s2   <= th_c;
			side_s2 <= side_s1;
		end
	end

	// ---- stage 3: theta in Q.30, reject a right angle or beyond
	logic signed [THETAW-1:0] theta_c;
	logic                     ang_ok_c;
	assign theta_c  = {th_s2, 6'b0};
	assign ang_ok_c = (theta_c < HALF_PI) && (theta_c > NEG_HALF_PI);

	logic                 v_s3;
	logic signed [ZW-1:0] z_s3;
	side_t                side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3    <= theta_c[ZW-1:0];
			side_s3 <= '{col: side_s2.col, row: side_s2.row, y: side_s2.y,
				ok: side_s2.ok && ang_ok_c};
		end
	end

	// ---- CORDIC
	logic                 cor_v;
	logic signed [XW-1:0] cos_c, sin_c;
	side_t                cor_side;

	cwa_cordic #(
		.ITER(TRIG_ITERATIONS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.z_in     (z_s3),
		.side_in  (side_s3),
		.out_v    (cor_v),
		.cos_out  (cos_c),
		.sin_out  (sin_c),
		.side_out (cor_side)
	);

	// ---- stage 4: dividends d*|s| and |y|*cos_half_fov
	logic            cpos_c, negx_c, negy_c;
	logic [DENW-1:0] smag_c;
	logic [CW-1:0]   ymag_c;
	logic [NW-1:0]   numx_c;
	logic [YPW-1:0]  numy_c;

	assign cpos_c = !cos_c[XW-1] && (cos_c != '0);
	assign negx_c = sin_c[XW-1];
	assign smag_c = negx_c ? DENW'(-sin_c) : DENW'(sin_c);
	assign negy_c = cor_side.y[DIMW-1];
	assign ymag_c = negy_c ? CW'(-cor_side.y) : CW'(cor_side.y);
	assign numx_c = NW'(focal_q) * NW'(smag_c);
	assign numy_c = YPW'(ymag_c) * YPW'(chf_q);

	logic            v_s4, negx_s4, negy_s4;
	logic [NW-1:0]   numx_s4;
	logic [YPW-1:0]  numy_s4;
	logic [DENW-1:0] den_s4;
	side_t           side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= cor_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s4 <= numx_c;
			numy_s4 <= numy_c;
			negx_s4 <= negx_c;
			negy_s4 <= negy_c;
			den_s4  <= cos_c[DENW-1:0];
			side_s4 <= '{col: cor_side.col, row: cor_side.row, y: cor_side.y,
				ok: cor_side.ok && cpos_c};
		end
	end

	// ---- dividers: x1 = d*s/c, y1 = y*chf*2^30/c
	logic [LANES-1:0][NW-1:0] div_num;
	logic [LANES-1:0]         div_neg_in, div_ovf, div_neg;
	logic [LANES-1:0][QW-1:0] div_quo;
	logic                     div_v;
	side_t                    div_side;

	assign div_num[0]    = numx_s4;
	assign div_num[1]    = NW'({numy_s4, {Q30{1'b0}}});
	assign div_neg_in[0] = negx_s4;
	assign div_neg_in[1] = negy_s4;

	cwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s4),
		.num_in   (div_num),
		.neg_in   (div_neg_in),
		.den_in   (den_s4),
		.side_in  (side_s4),
		.out_v    (div_v),
		.quo_out  (div_quo),
		.ovf_out  (div_ovf),
		.neg_out  (div_neg),
		.side_out (div_side)
	);

	// ---- stage 5: strict bounds in Q.16 and rounding sums
	logic signed [BW-1:0] x1_c, y1_c, hw16_c, hh16_c;
	logic signed [SW-1:0] sumx_c, sumy_c;
	logic                 inb_c;

	assign x1_c   = div_neg[0] ? -$signed(BW'(div_quo[0])) : $signed(BW'(div_quo[0]));
	assign y1_c   = div_neg[1] ? -$signed(BW'(div_quo[1])) : $signed(BW'(div_quo[1]));
	assign hw16_c = $signed(BW'({hw, 16'b0}));
	assign hh16_c = $signed(BW'({hh, 16'b0}));
	assign inb_c  = !div_ovf[0] && !div_ovf[1] &&
		(x1_c < hw16_c) && (x1_c > (ONE_Q16 - hw16_c)) &&
		(y1_c < hh16_c) && (y1_c > (ONE_Q16 - hh16_c));
	assign sumx_c = SW'(x1_c) + SW'(hw16_c) + HALF_Q16;
	assign sumy_c = SW'(y1_c) + SW'(hh16_c) + HALF_Q16;

	logic           v_s5;
	logic [SW-1:0]  sumx_s5, sumy_s5;
	side_t          side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sumx_s5 <= sumx_c;
			sumy_s5 <= sumy_c;
			side_s5 <= '{col: div_side.col, row: div_side.row, y: div_side.y,
				ok: div_side.ok && inb_c};
		end
	end

	// ---- stage 6: round, clamp to image edge, select
	logic [PW-1:0] px_c, py_c, limx_c, limy_c, cx1_c, cy1_c, cx2_c, cy2_c;
	src_t          res_c;

	assign px_c   = sumx_s5[SW-1:16];
	assign py_c   = sumy_s5[SW-1:16];
	assign limx_c = PW'({hw, 1'b0}) - PW'(1);
	assign limy_c = PW'({hh, 1'b0}) - PW'(1);
	assign cx1_c  = (px_c > limx_c) ? limx_c : px_c;
	assign cy1_c  = (py_c > limy_c) ? limy_c : py_c;
	assign cx2_c  = (cx1_c > CMAX) ? CMAX : cx1_c;
	assign cy2_c  = (cy1_c > CMAX) ? CMAX : cy1_c;

	always_comb begin
		if (side_s5.ok) begin
			res_c = '{src_col: cx2_c[CW-1:0], src_row: cy2_c[CW-1:0], remapped: 1'b1};
		end else begin
			res_c = '{src_col: side_s5.col, src_row: side_s5.row, remapped: 1'b0};
		end
	end

	logic v_s6;
	src_t res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= res_c;
		end
	end

	// ---- output register and skid
	logic out_v_q, out_free, hand;
	src_t out_data_q, skid_data_q;

	assign out_free = !out_v_q || !src_stall;
	assign hand     = en && v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || hand;
			skid_v_q <= 1'b0;
		end else if (hand) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_v_q ? skid_data_q : res_s6;
		end
		if (!out_free && hand) begin
			skid_data_q <= res_s6;
		end
	end

	assign src_valid = out_v_q;
	assign src_data  = out_data_q;

	`CWA_ASSERT_NOW(a_skid_behind_full_out, skid_v_q, out_v_q)
	`CWA_ASSERT_NEXT(a_skid_catches_item, hand && out_v_q && src_stall, skid_v_q)
	`CWA_ASSERT_NEXT(a_skid_drains, skid_v_q && !src_stall, out_v_q && !skid_v_q)
	`CWA_ASSERT_NOW(a_src_in_coord_range, out_v_q,
		((out_data_q.src_col & ~COORD_MASK) == '0) && ((out_data_q.src_row & ~COORD_MASK) == '0))

endmodule

`default_nettype wire

FILE: tb/cylindrical_warp_address_checker.sv
// ----------------------------------------------------------------------------
// cylindrical_warp_address_checker
// Watches the pixel, source and register channels of the warp address block,
// predicts the source coordinate of every accepted pixel and compares it with
// the source items that come out, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cylindrical_warp_address_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	input  logic                         pix_stall,
	input  cwa_pkg::pix_t                pix_data,
	input  logic                         src_valid,
	input  logic                         src_stall,
	input  cwa_pkg::src_t                src_data,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [cwa_pkg::CFG_IDXW-1:0] cfg_index,
	input  logic [cwa_pkg::CFGW-1:0]     cfg_data,
	output int                           fail_count,
	output int                           pending
);
	import cwa_pkg::*;

	localparam int     ROT_STEPS = 16;
	localparam longint RIGHT_ANGLE = 64'd1686629713;
	localparam longint GAIN = 64'd652032874;
	localparam longint UNIT = 64'd65536;
	localparam longint UNIT_Q30 = 64'd1073741824;
	localparam longint COORD_MAX = 64'd4095;

	localparam longint ROT_ANGLE [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	logic [DIMW-1:0] img_w, img_h;
	logic [FDW-1:0]  focal;
	logic [IRW-1:0]  inv_r;
	logic [CHW-1:0]  cos_fov;
	src_t            expected_src[$];

	assign pending = expected_src.size();

	// round half up back into pixel units, clamped to the image and the field
	function automatic longint to_pixel(longint v, longint half);
		longint p;
		p = (v + half * UNIT + UNIT / 2) / UNIT;
		if (p > 2 * half - 1)
			p = 2 * half - 1;
		if (p > COORD_MAX)
			p = COORD_MAX;
		if (p < 0)
			p = 0;
		return p;
	endfunction

	function automatic src_t warp_source(pix_t p);
		longint hw, hh, x, y, theta, cx, cy, z, dx, dy, x1, y1;
		src_t r;
		hw = longint'(img_w) >> 1;
		hh = longint'(img_h) >> 1;
		x = longint'(p.out_col) - hw;
		y = longint'(p.out_row) - hh;
		r.src_col = p.out_col;
		r.src_row = p.out_row;
		r.remapped = 1'b0;
		if (x < 1 - hw || x > hw - 1 || y < 1 - hh || y > hh - 1)
			return r;
		theta = x * longint'(inv_r) * 64;
		if (theta >= RIGHT_ANGLE || theta <= -RIGHT_ANGLE)
			return r;
		cx = GAIN;
		cy = 0;
		z = theta;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z -= ROT_ANGLE[i];
			end else begin
				cx += dx;
				cy -= dy;
				z += ROT_ANGLE[i];
			end
		end
		if (cx <= 0)
			return r;
		// signed / truncates toward zero, as the divider does
		x1 = (longint'(focal) * cy) / cx;
		y1 = (y * longint'(cos_fov) * UNIT_Q30) / cx;
		if (!(x1 < hw * UNIT && x1 > (1 - hw) * UNIT && y1 < hh * UNIT && y1 > (1 - hh) * UNIT))
			return r;
		r.src_col = CW'(to_pixel(x1, hw));
		r.src_row = CW'(to_pixel(y1, hh));
		r.remapped = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		src_t want;
		if (!arst_n) begin
			img_w <= 13'd640;
			img_h <= 13'd480;
			focal <= 29'd32296140;
			inv_r <= 24'd28553;
			cos_fov <= 17'd54964;
			fail_count <= 0;
			expected_src.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  img_w <= cfg_data[DIMW-1:0];
					CFG_IMAGE_HEIGHT: img_h <= cfg_data[DIMW-1:0];
					CFG_FOCAL:        focal <= cfg_data[FDW-1:0];
					CFG_INV_RADIUS:   inv_r <= cfg_data[IRW-1:0];
					CFG_COS_HALF_FOV: cos_fov <= cfg_data[CHW-1:0];
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall)
				expected_src = {expected_src, warp_source(pix_data)};
			if (src_valid && !src_stall) begin
				if (expected_src.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected source item %p", src_data);
				end else begin
					want = expected_src.pop_front();
					if (want.src_col !== src_data.src_col || want.src_row !== src_data.src_row ||
							want.remapped !== src_data.remapped) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("source mismatch: expected col %0d row %0d remap %0b, got col %0d row %0d remap %0b",
								want.src_col, want.src_row, want.remapped,
								src_data.src_col, src_data.src_row, src_data.remapped);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/cylindrical_warp_address_top_test.sv
// ----------------------------------------------------------------------------
// cylindrical_warp_address_top_test
// Drives pixel coordinates through the warp address block under a series of
// register settings (defaults, extremes, random fields of view) with random
// gaps and output stalls; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module cylindrical_warp_address_top_test;
	import cwa_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 106;

	logic                clk;
	logic                arst_n;
	logic                pix_valid;
	logic                pix_stall;
	pix_t                pix_data;
	logic                src_valid;
	logic                src_stall;
	src_t                src_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_IDXW-1:0] cfg_index;
	logic [CFGW-1:0]     cfg_data;
	int                  fail_count;
	int                  pending;

	logic pix_took, cfg_took, src_took;
	bit   hold_req;
	int   idle_cycles;
	int   cur_w, cur_h;

	cylindrical_warp_address_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
		.src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cylindrical_warp_address_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
		.src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// handshake results of the last edge, read back at the falling edge
	always @(posedge clk) begin
		pix_took <= pix_valid && !pix_stall;
		cfg_took <= cfg_valid && cfg_ready;
		src_took <= src_valid && !src_stall;
	end

	always @(posedge clk) begin
		if (!arst_n || pix_took || cfg_took || src_took)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("cylindrical_warp_address_top test failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random stalls, one long hold-off when asked
	initial begin
		int n;
		bit quiet;
		src_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				src_stall = 1'b1;
				repeat (400) @(negedge clk);
			end
			quiet = ($urandom_range(0, 3) == 0);
			n = quiet ? 0 : gap_len();
			src_stall = (n != 0);
			repeat (n) @(negedge clk);
			src_stall = 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	task automatic send_pixel(logic [CW-1:0] col, logic [CW-1:0] row, bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if (n != 0) begin
			pix_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		pix_data.out_col = col;
		pix_data.out_row = row;
		pix_valid = 1'b1;
		do @(negedge clk); while (!pix_took);
	endtask

	task automatic write_reg(logic [CFG_IDXW-1:0] idx, logic [CFGW-1:0] value);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(negedge clk); while (!cfg_took);
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		pix_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_view(int w, int h, longint d, longint ir, int cf);
		write_reg(CFG_IMAGE_WIDTH, CFGW'(w));
		write_reg(CFG_IMAGE_HEIGHT, CFGW'(h));
		write_reg(CFG_FOCAL, CFGW'(d));
		write_reg(CFG_INV_RADIUS, CFGW'(ir));
		write_reg(CFG_COS_HALF_FOV, CFGW'(cf));
		cur_w = w;
		cur_h = h;
	endtask

	// mostly inside the image so the warp path is exercised, the rest anywhere
	function automatic logic [CW-1:0] pick_coord(int dim);
		int top;
		top = (dim > 4096 ? 4096 : dim) - 1;
		if ($urandom_range(0, 4) == 0)
			return CW'($urandom_range(0, 4095));
		return CW'($urandom_range(0, top));
	endfunction

	initial begin
		int hw;
		longint d, ir, ir_max;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		cur_w = 640;
		cur_h = 480;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults: corners, center, inner-range edges, field extremes
		send_pixel(12'd0, 12'd0, 0);
		send_pixel(12'd4095, 12'd4095, 0);
		send_pixel(12'd320, 12'd240, 0);
		send_pixel(12'd1, 12'd1, 0);
		send_pixel(12'd639, 12'd479, 0);
		send_pixel(12'd640, 12'd480, 0);
		send_pixel(12'd0, 12'd240, 0);
		send_pixel(12'd320, 12'd0, 0);
		send_pixel(12'd4095, 12'd0, 0);
		send_pixel(12'd0, 12'd4095, 0);
		send_pixel(12'hAAA, 12'h555, 0);
		send_pixel(12'h555, 12'hAAA, 0);
		send_pixel(12'd2, 12'd2, 0);
		send_pixel(12'd638, 12'd478, 0);
		send_pixel(12'd321, 12'd239, 1);
		send_pixel(12'd319, 12'd241, 1);
		settle();

		// writes to indexes past the register list are ignored
		for (int idx = CFG_COS_HALF_FOV + 1; idx < 2 ** CFG_IDXW; idx++)
			write_reg(CFG_IDXW'(idx), CFGW'($urandom));

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_view(2, 2, 0, 0, 0);
				1: load_view(4096, 4096, 64'h1FFF_FFFF, 64'hFF_FFFF, 65536);
				2: load_view(3, 4095, 64'h1FFF_FFFF, 64'hFF_FFFF, 65536);
				default: begin
					cur_w = $urandom_range(2, 4096);
					hw = cur_w / 2;
					ir_max = 64'd26350000 / hw;
					if (ir_max > 64'hFF_FFFF)
						ir_max = 64'hFF_FFFF;
					ir = $urandom_range(int'(ir_max / 4), int'(ir_max));
					d = longint'(hw) * 65536 * $urandom_range(60, 140) / 100;
					if (d > 64'h1FFF_FFFF)
						d = 64'h1FFF_FFFF;
					load_view(cur_w, $urandom_range(2, 4096), d, ir, $urandom_range(30000, 65536));
				end
			endcase
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 3 && k == 20)
					hold_req = 1'b1;
				send_pixel(pick_coord(cur_w), pick_coord(cur_h), 1);
			end
			settle();
		end

		if (fail_count == 0)
			$display("cylindrical_warp_address_top test passed");
		else
			$display("cylindrical_warp_address_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
